// ===== rtl/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package mhpq_pkg;

	localparam int CAPACITY    = 127;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY + 1);
	localparam int DEPTH       = 1 << IDX_W;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic                           cmd;
		logic signed [VALUE_WIDTH-1:0]  value;
	} mhpq_req_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [1:0]         status;
		logic [6:0]         count;
		logic signed [31:0] top_value;
		logic               top_valid;
	} mhpq_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_CHK,
		S_DN_CMP,
		S_DONE
	} mhpq_state_t;

	typedef enum logic [1:0] {
		RD_LAST,
		RD_PARENT,
		RD_CHILD
	} mhpq_rd_t;

	// Controller to datapath.
	typedef struct packed {
		logic     start;
		logic     load_last;
		logic     wr_val;
		logic     wr_parent;
		logic     wr_child;
		mhpq_rd_t rd_sel;
	} mhpq_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic ins_ok;
		logic rem_more;
		logic at_root;
		logic leaf;
		logic up_move;
		logic dn_move;
	} mhpq_stat_t;

endpackage

// ===== rtl/mhpq_ctrl.sv =====
// Sequencing state machine for heap insert and remove.
// Depends on mhpq_pkg; drives the datapath only through command signals.
module mhpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                out_free,
	input  mhpq_pkg::mhpq_stat_t st,
	output mhpq_pkg::mhpq_cmd_t  cmd,
	output logic                req_stall,
	output logic                emit
);
	import mhpq_pkg::*;

	mhpq_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (st.ins_ok) state_nxt = S_UP_CHK;
					else if (st.rem_more) state_nxt = S_DN_LOAD;
					else state_nxt = S_DONE;
				end
			end
			S_UP_CHK:  state_nxt = st.at_root ? S_DONE : S_UP_CMP;
			S_UP_CMP:  state_nxt = st.up_move ? S_UP_CHK : S_DONE;
			S_DN_LOAD: state_nxt = S_DN_CHK;
			S_DN_CHK:  state_nxt = st.leaf ? S_DONE : S_DN_CMP;
			S_DN_CMP:  state_nxt = st.dn_move ? S_DN_CHK : S_DONE;
			S_DONE:    state_nxt = out_free ? S_IDLE : S_DONE;
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.rd_sel = RD_LAST;
		emit      = 1'b0;
		req_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.start  = req_valid;
				cmd.rd_sel = RD_LAST;
			end
			S_UP_CHK: begin
				cmd.rd_sel = RD_PARENT;
				cmd.wr_val = st.at_root;
			end
			S_UP_CMP: begin
				cmd.rd_sel    = RD_PARENT;
				cmd.wr_parent = st.up_move;
				cmd.wr_val    = !st.up_move;
			end
			S_DN_LOAD: begin
				cmd.load_last = 1'b1;
			end
			S_DN_CHK: begin
				cmd.rd_sel = RD_CHILD;
				cmd.wr_val = st.leaf;
			end
			S_DN_CMP: begin
				cmd.rd_sel   = RD_CHILD;
				cmd.wr_child = st.dn_move;
				cmd.wr_val   = !st.dn_move;
			end
			S_DONE: begin
				emit = out_free;
			end
			default: begin
				cmd.rd_sel = RD_LAST;
			end
		endcase
	end

endmodule

// ===== rtl/mhpq_dp.sv =====
// Heap datapath: entry memory, count, root copy and the moving value.
// Depends on mhpq_pkg; the sift walks a hole through the tree one level per step.
module mhpq_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mhpq_pkg::mhpq_req_t  req,
	input  mhpq_pkg::mhpq_cmd_t  cmd,
	output mhpq_pkg::mhpq_stat_t st,
	output mhpq_pkg::mhpq_rsp_t  rsp
);
	import mhpq_pkg::*;

	logic [VALUE_WIDTH-1:0] mem [DEPTH];

	logic [IDX_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        pos_q;
	logic [VALUE_WIDTH-1:0]  val_q;
	logic [VALUE_WIDTH-1:0]  rem_q;
	logic [VALUE_WIDTH-1:0]  root_q;
	logic [1:0]              stat_q;
	logic [VALUE_WIDTH-1:0]  rd_a_q;
	logic [VALUE_WIDTH-1:0]  rd_b_q;

	logic [IDX_W:0]          left_idx;
	logic [IDX_W:0]          right_idx;
	logic [IDX_W-1:0]        addr_a;
	logic                    right_big;
	logic [VALUE_WIDTH-1:0]  big_val;
	logic [IDX_W-1:0]        big_idx;
	logic                    ins_ok;
	logic                    rem_ok;
	logic                    we;
	logic [VALUE_WIDTH-1:0]  wdata;

	assign left_idx  = {pos_q, 1'b0};
	assign right_idx = {pos_q, 1'b1};

	always_comb begin
		case (cmd.rd_sel)
			RD_LAST:   addr_a = cnt_q;
			RD_PARENT: addr_a = pos_q >> 1;
			RD_CHILD:  addr_a = left_idx[IDX_W-1:0];
			default:   addr_a = cnt_q;
		endcase
	end

	// Left child wins a tie; the right child only counts if it exists.
	assign right_big = (right_idx <= {1'b0, cnt_q}) && ($signed(rd_b_q) > $signed(rd_a_q));
	assign big_val   = right_big ? rd_b_q : rd_a_q;
	assign big_idx   = right_big ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

	assign ins_ok = (req.cmd == CMD_INSERT) && (cnt_q < IDX_W'(CAPACITY));
	assign rem_ok = (req.cmd == CMD_REMOVE) && (cnt_q != '0);

	assign st.ins_ok   = ins_ok;
	assign st.rem_more = rem_ok && (cnt_q > IDX_W'(1));
	assign st.at_root  = (pos_q == IDX_W'(1));
	assign st.leaf     = left_idx > {1'b0, cnt_q};
	assign st.up_move  = $signed(val_q) > $signed(rd_a_q);
	assign st.dn_move  = $signed(big_val) > $signed(val_q);

	assign we = cmd.wr_val || cmd.wr_parent || cmd.wr_child;

	always_comb begin
		if (cmd.wr_val) wdata = val_q;
		else if (cmd.wr_parent) wdata = rd_a_q;
		else wdata = big_val;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_q] <= wdata;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[right_idx[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			if (ins_ok) cnt_q <= cnt_q + IDX_W'(1);
			else if (rem_ok) cnt_q <= cnt_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q  <= req.value;
			rem_q  <= '0;
			stat_q <= STAT_OK;
			if (ins_ok) begin
				pos_q <= cnt_q + IDX_W'(1);
			end else if (rem_ok) begin
				rem_q <= root_q;
				pos_q <= IDX_W'(1);
			end else if (req.cmd == CMD_INSERT) begin
				stat_q <= STAT_FULL;
			end else begin
				stat_q <= STAT_EMPTY;
			end
		end
		if (cmd.load_last) begin
			val_q <= rd_a_q;
		end
		if (cmd.wr_parent) begin
			pos_q <= pos_q >> 1;
		end
		if (cmd.wr_child) begin
			pos_q <= big_idx;
		end
		if (we && (pos_q == IDX_W'(1))) begin
			root_q <= wdata;
		end
	end

	assign rsp.removed_value = rem_q;
	assign rsp.status        = stat_q;
	assign rsp.count         = cnt_q;
	assign rsp.top_value     = (cnt_q != '0) ? root_q : '0;
	assign rsp.top_valid     = (cnt_q != '0);

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IDX_W'(CAPACITY))
		else $error("entry count above capacity");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (pos_q != '0) && (pos_q <= cnt_q))
		else $error("heap write outside the live entries");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && ins_ok |=> cnt_q == $past(cnt_q) + IDX_W'(1))
		else $error("insert did not grow the count");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_val, cmd.wr_parent, cmd.wr_child}))
		else $error("more than one write source selected");
`endif

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Max-heap priority queue, 127 signed 32-bit entries; depends on mhpq_pkg, mhpq_ctrl, mhpq_dp.
// A rejected request, or a remove of the last entry, goes straight to the result; an insert
// climbs one level per compare step until it reaches the root or stops, and a remove descends
// one level per compare step until it reaches a leaf or stops; the tree has 7 levels.
// One transaction in work at a time, the next taken the cycle after its result registers.
// Reset clears the count and control state at once; memory contents need no clearing.
module max_heap_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mhpq_pkg::mhpq_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mhpq_pkg::mhpq_rsp_t rsp
);
	import mhpq_pkg::*;

	mhpq_cmd_t  cmd;
	mhpq_stat_t st;
	mhpq_rsp_t  rsp_nxt;
	mhpq_rsp_t  rsp_q;
	logic       rsp_valid_q;
	logic       out_free;
	logic       emit;

	assign out_free = !rsp_valid_q || !rsp_stall;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.st        (st),
		.cmd       (cmd),
		.req_stall (req_stall),
		.emit      (emit)
	);

	mhpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sv/mhpq_checker.sv =====
// Checker for the max-heap priority queue: keeps its own heap, predicts every result
// and compares it with what the block returns. Depends on mhpq_pkg.
module mhpq_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  mhpq_pkg::mhpq_req_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  mhpq_pkg::mhpq_rsp_t rsp,
	output int                  errors,
	output int                  pending
);
	import mhpq_pkg::*;

	logic signed [VALUE_WIDTH-1:0] heap_mem [1:CAPACITY];
	int                            heap_len;
	mhpq_rsp_t                     expected_rsp [$];

	function automatic void swap_entries(input int a, input int b);
		logic signed [VALUE_WIDTH-1:0] tmp;
		tmp = heap_mem[a];
		heap_mem[a] = heap_mem[b];
		heap_mem[b] = tmp;
	endfunction

	// Applies one transaction to the shadow heap and returns the result it should produce.
	function automatic mhpq_rsp_t heap_step(input mhpq_req_t r);
		mhpq_rsp_t o;
		int        pos;
		int        kid;
		logic      done;
		o = '0;
		o.status = STAT_OK;
		if (r.cmd == CMD_INSERT) begin
			if (heap_len >= CAPACITY) begin
				o.status = STAT_FULL;
			end else begin
				heap_len++;
				heap_mem[heap_len] = r.value;
				pos = heap_len;
				while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
					swap_entries(pos, pos / 2);
					pos = pos / 2;
				end
			end
		end else if (heap_len == 0) begin
			o.status = STAT_EMPTY;
		end else begin
			o.removed_value = heap_mem[1];
			heap_mem[1] = heap_mem[heap_len];
			heap_len--;
			pos = 1;
			done = 1'b0;
			while (!done) begin
				kid = 2 * pos;
				if (kid > heap_len) begin
					done = 1'b1;
				end else begin
					// The right child wins only when strictly greater.
					if (kid + 1 <= heap_len && heap_mem[kid + 1] > heap_mem[kid])
						kid = kid + 1;
					if (heap_mem[kid] > heap_mem[pos]) begin
						swap_entries(kid, pos);
						pos = kid;
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		o.count     = heap_len[6:0];
		o.top_valid = (heap_len > 0);
		o.top_value = (heap_len > 0) ? heap_mem[1] : '0;
		return o;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		mhpq_rsp_t want;
		if (!arst_n) begin
			heap_len = 0;
			expected_rsp.delete();
			errors = 0;
			pending = 0;
		end else begin
			// The result side is handled first, so a transaction accepted at the same edge
			// can never satisfy a result that came too early.
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
				end else begin
					want = expected_rsp.pop_front();
					compare_field("removed_value", want.removed_value, rsp.removed_value);
					compare_field("status", want.status, rsp.status);
					compare_field("count", want.count, rsp.count);
					compare_field("top_value", want.top_value, rsp.top_value);
					compare_field("top_valid", want.top_valid, rsp.top_valid);
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(heap_step(req));
			pending = expected_rsp.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the max-heap priority queue testbench: clock, reset, stimulus and verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and mhpq_checker.
module tb;
	import mhpq_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	mhpq_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	mhpq_rsp_t rsp;
	int        errors;
	int        pending;

	int send_idle_pct  = 30;
	int recv_stall_pct = 60;
	int holds_asked    = 0;

	max_heap_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	mhpq_checker heap_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random stalls, or a long hold-off whenever the stimulus asks for one.
	initial begin
		int hold_left;
		int holds_done;
		rsp_stall = 1'b0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Called and returns at a falling edge; returns once the transaction is accepted.
	task automatic send_req(input logic cmd, input logic signed [VALUE_WIDTH-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{cmd: cmd, value: value};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// Small values give plenty of ties; extremes and full-range values cover every bit.
	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom_range(7) - 4;
			1: begin
				case ($urandom_range(3))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_mixed(input int n, input int insert_pct);
		repeat (n) begin
			if ($urandom_range(99) < insert_pct)
				send_req(CMD_INSERT, pick_value());
			else
				send_req(CMD_REMOVE, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty remove, extremes, ties, then drain past empty.
		send_req(CMD_REMOVE, '0);
		send_req(CMD_INSERT, '0);
		send_req(CMD_INSERT, VAL_MAX);
		send_req(CMD_INSERT, VAL_MIN);
		send_req(CMD_INSERT, '1);
		send_req(CMD_INSERT, 5);
		send_req(CMD_INSERT, 5);
		send_req(CMD_INSERT, 32'h5555_5555);
		send_req(CMD_INSERT, 32'haaaa_aaaa);
		send_req(CMD_INSERT, VAL_MAX);
		repeat (10) send_req(CMD_REMOVE, $urandom);
		send_req(CMD_REMOVE, '1);
		send_req(CMD_INSERT, 1);
		send_req(CMD_INSERT, 2);
		send_req(CMD_REMOVE, '0);

		send_mixed(80, 55);

		// Overfill while the result side holds off, so the input backs up; 130 inserts
		// always run past capacity, and 135 removes always run past empty.
		holds_asked++;
		send_mixed(130, 100);
		send_mixed(135, 0);
		wait_drained();

		send_idle_pct = 60;
		recv_stall_pct = 30;
		send_mixed(80, 60);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_mixed(40, 70);
		holds_asked++;
		send_mixed(60, 50);

		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
